>>> src/utf8d_pkg.sv
// Shared widths, byte codes and types for the UTF-8 byte stream decoder.
`default_nettype none
package utf8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int REM_W  = 2;
	localparam int CONT_W = 6;

	localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;

	localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hF4;

	localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
	localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
	localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
	localparam logic [REM_W-1:0] REM_THREE = 2'd3;

	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] cp;
	} dec_res_t;

endpackage
`default_nettype wire

>>> src/utf8d_decode.sv
// Sequence state and per-byte decode logic of the UTF-8 decoder.
`default_nettype none
module utf8d_decode (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [utf8d_pkg::BYTE_W-1:0]   byte_s1,
	input  wire logic                           advance,
	output utf8d_pkg::dec_res_t                 res
);

	logic [utf8d_pkg::REM_W-1:0] rem_q;
	logic [utf8d_pkg::CP_W-1:0]  partial_q;
	logic [utf8d_pkg::REM_W-1:0] rem_d;
	logic [utf8d_pkg::CP_W-1:0]  partial_d;
	logic [utf8d_pkg::CP_W-1:0]  shifted;

	assign shifted = {partial_q[utf8d_pkg::CP_W-utf8d_pkg::CONT_W-1:0],
		byte_s1[utf8d_pkg::CONT_W-1:0]};

	always_comb begin
		rem_d     = rem_q;
		partial_d = partial_q;
		res.emit  = 1'b0;
		res.cp    = shifted;
		priority if (rem_q != utf8d_pkg::REM_NONE) begin
			rem_d = rem_q - utf8d_pkg::REM_ONE;
			if (rem_q == utf8d_pkg::REM_ONE) begin
				res.emit  = 1'b1;
				partial_d = '0;
			end else begin
				partial_d = shifted;
			end
		end else if (byte_s1 < utf8d_pkg::ASCII_LIMIT) begin
			res.emit = 1'b1;
			res.cp   = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, byte_s1};
		end else if (byte_s1 >= utf8d_pkg::LEAD2_LO && byte_s1 <= utf8d_pkg::LEAD2_HI) begin
			rem_d     = utf8d_pkg::REM_ONE;
			partial_d = {{(utf8d_pkg::CP_W-5){1'b0}}, byte_s1[4:0]};
		end else if (byte_s1 >= utf8d_pkg::LEAD3_LO && byte_s1 <= utf8d_pkg::LEAD3_HI) begin
			rem_d     = utf8d_pkg::REM_TWO;
			partial_d = {{(utf8d_pkg::CP_W-4){1'b0}}, byte_s1[3:0]};
		end else if (byte_s1 >= utf8d_pkg::LEAD4_LO && byte_s1 <= utf8d_pkg::LEAD4_HI) begin
			rem_d     = utf8d_pkg::REM_THREE;
			partial_d = {{(utf8d_pkg::CP_W-3){1'b0}}, byte_s1[2:0]};
		end else begin
			res.emit = 1'b1;
			res.cp   = utf8d_pkg::REPLACEMENT_CP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= utf8d_pkg::REM_NONE;
			partial_q <= '0;
		end else if (advance) begin
			rem_q     <= rem_d;
			partial_q <= partial_d;
		end
	end

`ifndef NO_ASSERTIONS
	// The gathered bits are cleared whenever no sequence is open.
	a_idle_partial_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q == utf8d_pkg::REM_NONE |-> partial_q == '0)
		else $error("partial value not cleared outside a sequence");

	// A code point is never emitted while more than one continuation is due.
	a_no_early_emit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rem_q != utf8d_pkg::REM_NONE && rem_q != utf8d_pkg::REM_ONE
		|-> !res.emit)
		else $error("code point emitted before the sequence ended");

	// The last continuation beat closes the sequence.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rem_q == utf8d_pkg::REM_ONE |=> rem_q == utf8d_pkg::REM_NONE)
		else $error("sequence still open after its last continuation");
`endif

endmodule
`default_nettype wire

>>> src/utf8d_out_reg.sv
// Result register of the UTF-8 decoder with its output handshake.
`default_nettype none
module utf8d_out_reg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire logic [utf8d_pkg::CP_W-1:0]   cp_d,
	output logic                              slot_free,
	output logic                              cp_valid,
	input  wire logic                         cp_ready,
	output logic [utf8d_pkg::CP_W-1:0]        code_point
);

	logic                        valid_s2;
	logic [utf8d_pkg::CP_W-1:0]  cp_s2;

	assign slot_free  = !valid_s2 || cp_ready;
	assign cp_valid   = valid_s2;
	assign code_point = cp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (cp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_s2 <= cp_d;
		end
	end

endmodule
`default_nettype wire

>>> src/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder top level: input register, decode stage and result register.
// Throughput is one byte per cycle unless the output stalls; byte_ready gates each byte.
// A completing byte passes the input register, then its code point the result register.
// Bytes that open or continue a sequence give no result and leave the output untouched.
// The output register is reloaded in the cycle it is taken, so stalls cost no bubbles.
// Reset clears the sequence state and all valid flags; data registers are not reset.
`default_nettype none
module utf8_byte_stream_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           byte_valid,
	output logic                                byte_ready,
	input  wire logic [utf8d_pkg::BYTE_W-1:0]   byte_in,
	output logic                                cp_valid,
	input  wire logic                           cp_ready,
	output logic [utf8d_pkg::CP_W-1:0]          code_point
);

	logic                          valid_s1;
	logic [utf8d_pkg::BYTE_W-1:0]  byte_s1;
	logic                          advance;
	logic                          slot_free;
	utf8d_pkg::dec_res_t           res;

	assign advance    = valid_s1 && (!res.emit || slot_free);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_in;
		end
	end

	utf8d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.advance (advance),
		.res     (res)
	);

	utf8d_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && res.emit),
		.cp_d       (res.cp),
		.slot_free  (slot_free),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.code_point (code_point)
	);

endmodule
`default_nettype wire
